>>> sv/sdrs_pkg.sv
// ----------------------------------------------------------------------------
// sdrs_pkg: shared types and constants of the disk request scheduler
// Field widths, request and result codes, and the slot record layout.
// ----------------------------------------------------------------------------
`default_nettype none

package sdrs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int BLOCK_W = 20;
    localparam int PRIO_W  = 2;
    localparam int TAG_W   = 16;
    localparam int ROT_W   = 16;
    localparam int LAT_W   = 21;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 32;
    localparam int SCORE_W = BLOCK_W + PRIO_W;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 144;
    localparam int M_PAD_W  = M_DATA_W - (BLOCK_W + 1 + PRIO_W + TAG_W + LAT_W + SUM_W + CNT_W);

    typedef enum logic {
        OP_ENQ  = 1'b0,
        OP_DISP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_ENQUEUED   = 2'd0,
        ST_FULL       = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_EMPTY      = 2'd3
    } t_status;

    typedef enum logic {
        REG_POLICY = 1'b0,
        REG_ROT    = 1'b1
    } t_reg;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [PRIO_W-1:0]  prio;
        logic               wr;
        logic [BLOCK_W-1:0] blk;
    } t_slot;

    typedef struct packed {
        logic               found;
        logic [BLOCK_W-1:0] seek;
        t_slot              slot;
    } t_best;

endpackage

`default_nettype wire

>>> sv/sdrs_ram.sv
// ----------------------------------------------------------------------------
// sdrs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/sdrs_score.sv
// ----------------------------------------------------------------------------
// sdrs_score: seek score and best-slot tracker
// Scores one slot a cycle while i_cmp is set and keeps the lowest-scoring slot seen so far.
// ----------------------------------------------------------------------------
`default_nettype none

module sdrs_score #(
    parameter int IDX_W = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_clear,
    input  wire logic                         i_cmp,
    input  wire logic [IDX_W-1:0]             i_idx,
    input  wire sdrs_pkg::t_slot              i_slot,
    input  wire logic [sdrs_pkg::BLOCK_W-1:0] i_head,
    input  wire logic                         i_policy,
    output sdrs_pkg::t_best                   o_best,
    output logic      [IDX_W-1:0]             o_best_idx
);

    logic                         r_found;
    logic [sdrs_pkg::BLOCK_W-1:0] r_dist;
    sdrs_pkg::t_slot              r_slot;
    logic [sdrs_pkg::SCORE_W-1:0] r_score;
    logic [IDX_W-1:0]             r_idx;

    logic [sdrs_pkg::BLOCK_W-1:0] w_dist;
    logic [sdrs_pkg::SCORE_W-1:0] w_score;
    logic                         w_take;

    always_comb begin
        w_dist  = (i_slot.blk >= i_head) ? (i_slot.blk - i_head) : (i_head - i_slot.blk);
        w_score = i_policy ? {w_dist, i_slot.prio} : '0;
        w_take  = i_cmp && (!r_found || (w_score < r_score));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
        if (w_take) begin
            r_dist  <= w_dist;
            r_slot  <= i_slot;
            r_score <= w_score;
            r_idx   <= i_idx;
        end
    end

    assign o_best     = '{found: r_found, seek: r_dist, slot: r_slot};
    assign o_best_idx = r_idx;

endmodule

`default_nettype wire

>>> sv/sstf_fcfs_disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// sstf_fcfs_disk_request_scheduler: table-based disk request scheduler
// Stores pending requests, dispatches lowest slot or shortest seek first,
// and keeps saturating latency and dispatch totals.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  s_axis  | in  | tuser: op; tdata: block_no, is_write, prio, buffer_tag
//  m_axis  | out | tuser: status; tdata: out_block .. served_total
//  apb     | in  | 0x0 policy, 0x4 rot_delay
//
//  Enqueue: take the beat, then test one slot a cycle until a free slot is found
//  or the last slot is reached, then load the result once the output is free.
//  Dispatch: scan every slot, one a cycle, through the table's single read port
//  and the score unit, then load the result once the output is free.
//  Reset empties the table at once through the valid bits; no clearing pass.
//  A waiting result holds in the output register; a new beat is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_fcfs_disk_request_scheduler #(
    parameter int QUEUE_DEPTH = sdrs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [19:0] block_no, [20] is_write, [22:21] prio, [38:23] buffer_tag
    input  wire logic [sdrs_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // [0] op
    input  wire logic                          i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [19:0] out_block, [20] out_write, [22:21] out_prio, [38:23] out_tag,
    // [59:39] latency, [107:60] sum_latency, [139:108] served_total
    output logic      [sdrs_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic      [1:0]                    o_m_axis_tuser,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LAST = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    sdrs_pkg::t_op                 r_op;
    sdrs_pkg::t_slot               r_req;
    logic [IDX_W-1:0]              r_idx;
    logic [IDX_W-1:0]              r_cmp_idx;
    logic                          r_cmp_vld;
    logic                          r_free_found;
    logic [QUEUE_DEPTH-1:0]        r_valid;
    logic [sdrs_pkg::BLOCK_W-1:0]  r_head;
    logic [sdrs_pkg::SUM_W-1:0]    r_accum, n_accum;
    logic [sdrs_pkg::CNT_W-1:0]    r_count, n_count;
    logic                          r_policy;
    logic [sdrs_pkg::ROT_W-1:0]    r_rot;
    logic                          r_m_tvalid;
    logic [sdrs_pkg::M_DATA_W-1:0] r_m_tdata;
    logic [1:0]                    r_m_tuser;

    logic                          w_s_accept;
    logic                          w_out_free;
    logic                          w_slot_free;
    logic                          w_idx_last;
    logic                          w_ram_we;
    logic [$bits(sdrs_pkg::t_slot)-1:0] w_ram_rdata;
    sdrs_pkg::t_slot               w_rd_slot;
    sdrs_pkg::t_best               w_best;
    logic [IDX_W-1:0]              w_best_idx;
    logic [sdrs_pkg::LAT_W-1:0]    w_lat;
    logic [sdrs_pkg::SUM_W:0]      w_sum;
    logic                          w_disp_hit;
    sdrs_pkg::t_status             w_status;
    sdrs_pkg::t_slot               w_out_slot;
    logic [sdrs_pkg::LAT_W-1:0]    w_out_lat;
    logic                          w_cfg_wr;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_m_tvalid || i_m_axis_tready;
    assign w_slot_free     = !r_valid[r_idx];
    assign w_idx_last      = (r_idx == LAST_IDX);
    assign w_ram_we        = (r_state == S_SCAN) && (r_op == sdrs_pkg::OP_ENQ) && w_slot_free;
    assign w_rd_slot       = sdrs_pkg::t_slot'(w_ram_rdata);

    sdrs_ram #(
        .WIDTH ($bits(sdrs_pkg::t_slot)),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_req),
        .i_raddr (r_idx),
        .o_rdata (w_ram_rdata)
    );

    sdrs_score #(
        .IDX_W (IDX_W)
    ) u_score (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_s_accept),
        .i_cmp      (r_cmp_vld),
        .i_idx      (r_cmp_idx),
        .i_slot     (w_rd_slot),
        .i_head     (r_head),
        .i_policy   (r_policy),
        .o_best     (w_best),
        .o_best_idx (w_best_idx)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_op == sdrs_pkg::OP_ENQ) begin
                    if (w_slot_free || w_idx_last) begin
                        n_state = S_FIN;
                    end
                end else if (w_idx_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_disp_hit = (r_op == sdrs_pkg::OP_DISP) && w_best.found;
        w_lat      = {1'b0, w_best.seek} + sdrs_pkg::LAT_W'(r_rot);
        w_sum      = {1'b0, r_accum} + (sdrs_pkg::SUM_W + 1)'(w_lat);
        n_accum    = w_sum[sdrs_pkg::SUM_W] ? '1 : w_sum[sdrs_pkg::SUM_W-1:0];
        n_count    = (&r_count) ? r_count : r_count + 1'b1;
        w_out_slot = w_best.slot;
        w_out_lat  = w_lat;
        if (r_op == sdrs_pkg::OP_ENQ) begin
            w_status = r_free_found ? sdrs_pkg::ST_ENQUEUED : sdrs_pkg::ST_FULL;
        end else begin
            w_status = w_best.found ? sdrs_pkg::ST_DISPATCHED : sdrs_pkg::ST_EMPTY;
        end
        if (!w_disp_hit) begin
            w_out_slot = '0;
            w_out_lat  = '0;
            n_accum    = r_accum;
            n_count    = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_op        <= sdrs_pkg::t_op'(i_s_axis_tuser);
            r_req.blk   <= i_s_axis_tdata[19:0];
            r_req.wr    <= i_s_axis_tdata[20];
            r_req.prio  <= i_s_axis_tdata[22:21];
            r_req.tag   <= i_s_axis_tdata[38:23];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_cmp_idx    <= '0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_cmp_vld <= (r_state == S_SCAN) && (r_op == sdrs_pkg::OP_DISP) && !w_slot_free;
            r_cmp_idx <= r_idx;
            if (w_s_accept) begin
                r_idx        <= '0;
                r_free_found <= 1'b0;
            end else if (r_state == S_SCAN) begin
                if (w_ram_we) begin
                    r_free_found <= 1'b1;
                end else if (!w_idx_last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_head  <= '0;
            r_accum <= '0;
            r_count <= '0;
        end else begin
            if (w_ram_we) begin
                r_valid[r_idx] <= 1'b1;
            end
            if ((r_state == S_FIN) && w_out_free && w_disp_hit) begin
                r_valid[w_best_idx] <= 1'b0;
                r_head              <= w_best.slot.blk;
                r_accum             <= n_accum;
                r_count             <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if ((r_state == S_FIN) && w_out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
        if ((r_state == S_FIN) && w_out_free) begin
            r_m_tuser <= w_status;
            r_m_tdata <= {{sdrs_pkg::M_PAD_W{1'b0}}, n_count, n_accum, w_out_lat,
                          w_out_slot.tag, w_out_slot.prio, w_out_slot.wr, w_out_slot.blk};
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0;
            r_rot    <= '0;
        end else if (w_cfg_wr) begin
            unique case (sdrs_pkg::t_reg'(paddr[2]))
                sdrs_pkg::REG_POLICY: r_policy <= pwdata[0];
                sdrs_pkg::REG_ROT:    r_rot    <= pwdata[sdrs_pkg::ROT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (sdrs_pkg::t_reg'(paddr[2]))
            sdrs_pkg::REG_POLICY: prdata = {31'd0, r_policy};
            sdrs_pkg::REG_ROT:    prdata = {{(32 - sdrs_pkg::ROT_W){1'b0}}, r_rot};
            default:              prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the disk request scheduler
// Replays a table of directed beats, then random enqueue and dispatch traffic
// under both policies and several rotational delays, with random gaps on the
// request side and stalls on the result side. Every result beat is compared
// field by field against a behavioural table model or a typed row's result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int BLOCK_W  = sdrs_pkg::BLOCK_W;
    localparam int PRIO_W   = sdrs_pkg::PRIO_W;
    localparam int TAG_W    = sdrs_pkg::TAG_W;
    localparam int ROT_W    = sdrs_pkg::ROT_W;
    localparam int LAT_W    = sdrs_pkg::LAT_W;
    localparam int SUM_W    = sdrs_pkg::SUM_W;
    localparam int CNT_W    = sdrs_pkg::CNT_W;
    localparam int S_DATA_W = sdrs_pkg::S_DATA_W;
    localparam int M_DATA_W = sdrs_pkg::M_DATA_W;

    typedef sdrs_pkg::t_op     t_op;
    typedef sdrs_pkg::t_status t_status;
    typedef sdrs_pkg::t_reg    t_reg;
    typedef sdrs_pkg::t_slot   t_slot;

    localparam t_op     OP_ENQ        = sdrs_pkg::OP_ENQ;
    localparam t_op     OP_DISP       = sdrs_pkg::OP_DISP;
    localparam t_status ST_ENQUEUED   = sdrs_pkg::ST_ENQUEUED;
    localparam t_status ST_FULL       = sdrs_pkg::ST_FULL;
    localparam t_status ST_DISPATCHED = sdrs_pkg::ST_DISPATCHED;
    localparam t_status ST_EMPTY      = sdrs_pkg::ST_EMPTY;
    localparam t_reg    REG_POLICY    = sdrs_pkg::REG_POLICY;
    localparam t_reg    REG_ROT       = sdrs_pkg::REG_ROT;

    localparam int DEPTH       = sdrs_pkg::QUEUE_DEPTH_DEF;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 144;
    localparam int DIR_ROWS    = 25;
    localparam int TAIL_CYCLES = DEPTH + 8;
    localparam int PRINT_CAP   = 40;
    localparam int SEEK_WEIGHT = 4;

    localparam logic [SUM_W-1:0] SUM_CEIL   = '1;
    localparam logic [CNT_W-1:0] CNT_CEIL   = '1;
    localparam logic [31:0]      SCORE_NONE = 32'h7FFF_FFFF;

    typedef enum logic {
        POL_FCFS = 1'b0,
        POL_SSTF = 1'b1
    } t_policy;

    typedef struct packed {
        t_status            st;
        logic [BLOCK_W-1:0] blk;
        logic               wr;
        logic [PRIO_W-1:0]  prio;
        logic [TAG_W-1:0]   tag;
        logic [LAT_W-1:0]   lat;
        logic [SUM_W-1:0]   sum;
        logic [CNT_W-1:0]   cnt;
    } t_disp_result;

    typedef struct packed {
        t_op                op;
        logic [BLOCK_W-1:0] blk;
        logic               wr;
        logic [PRIO_W-1:0]  prio;
        logic [TAG_W-1:0]   tag;
        logic               typed;
        t_disp_result       want;
    } t_dir_row;

    localparam t_disp_result NO_WANT = '0;

    localparam t_dir_row DIR [DIR_ROWS] = '{
        '{OP_DISP, 20'h00000, 1'b0, 2'd0, 16'h0000, 1'b1,
          '{ST_EMPTY, 20'h0, 1'b0, 2'd0, 16'h0, 21'h0, 48'h0, 32'd0}},
        '{OP_ENQ,  20'hFFFFF, 1'b1, 2'd3, 16'hFFFF, 1'b1,
          '{ST_ENQUEUED, 20'h0, 1'b0, 2'd0, 16'h0, 21'h0, 48'h0, 32'd0}},
        '{OP_DISP, 20'h00000, 1'b0, 2'd0, 16'h0000, 1'b1,
          '{ST_DISPATCHED, 20'hFFFFF, 1'b1, 2'd3, 16'hFFFF, 21'h0FFFFF, 48'h0FFFFF, 32'd1}},
        '{OP_ENQ,  20'h00000, 1'b0, 2'd0, 16'h0000, 1'b1,
          '{ST_ENQUEUED, 20'h0, 1'b0, 2'd0, 16'h0, 21'h0, 48'h0FFFFF, 32'd1}},
        '{OP_DISP, 20'h00000, 1'b0, 2'd0, 16'h0000, 1'b1,
          '{ST_DISPATCHED, 20'h0, 1'b0, 2'd0, 16'h0, 21'h0FFFFF, 48'h1FFFFE, 32'd2}},
        '{OP_DISP, 20'h00000, 1'b0, 2'd0, 16'h0000, 1'b1,
          '{ST_EMPTY, 20'h0, 1'b0, 2'd0, 16'h0, 21'h0, 48'h1FFFFE, 32'd2}},
        '{OP_ENQ,  20'h00005, 1'b0, 2'd1, 16'h1234, 1'b0, NO_WANT},
        '{OP_ENQ,  20'h80000, 1'b1, 2'd2, 16'h8000, 1'b0, NO_WANT},
        '{OP_ENQ,  20'h00005, 1'b0, 2'd0, 16'h0001, 1'b0, NO_WANT},
        '{OP_ENQ,  20'h7FFFF, 1'b1, 2'd3, 16'h7FFF, 1'b0, NO_WANT},
        '{OP_ENQ,  20'hAAAAA, 1'b0, 2'd2, 16'hAAAA, 1'b0, NO_WANT},
        '{OP_ENQ,  20'h55555, 1'b1, 2'd1, 16'h5555, 1'b0, NO_WANT},
        '{OP_ENQ,  20'h00001, 1'b0, 2'd3, 16'h00FF, 1'b0, NO_WANT},
        '{OP_ENQ,  20'hFFFFE, 1'b1, 2'd0, 16'hFF00, 1'b0, NO_WANT},
        '{OP_ENQ,  20'h12345, 1'b0, 2'd1, 16'hBEEF, 1'b0, NO_WANT},
        '{OP_ENQ,  20'h00000, 1'b1, 2'd2, 16'h0F0F, 1'b0, NO_WANT},
        '{OP_ENQ,  20'hFFFFF, 1'b0, 2'd3, 16'hF0F0, 1'b0, NO_WANT},
        '{OP_ENQ,  20'h40000, 1'b1, 2'd0, 16'h4000, 1'b0, NO_WANT},
        '{OP_ENQ,  20'h0000F, 1'b0, 2'd1, 16'h000F, 1'b0, NO_WANT},
        '{OP_ENQ,  20'hC0000, 1'b1, 2'd2, 16'hC000, 1'b0, NO_WANT},
        '{OP_ENQ,  20'h3C3C3, 1'b0, 2'd0, 16'h3C3C, 1'b0, NO_WANT},
        '{OP_ENQ,  20'h00002, 1'b1, 2'd3, 16'h0002, 1'b0, NO_WANT},
        '{OP_ENQ,  20'hFFFFF, 1'b1, 2'd3, 16'hFFFF, 1'b1,
          '{ST_FULL, 20'h0, 1'b0, 2'd0, 16'h0, 21'h0, 48'h1FFFFE, 32'd2}},
        '{OP_DISP, 20'h00000, 1'b0, 2'd0, 16'h0000, 1'b0, NO_WANT},
        '{OP_ENQ,  20'h00003, 1'b1, 2'd1, 16'hA5A5, 1'b0, NO_WANT}
    };

    localparam t_policy PH_POL    [PHASES] = '{POL_FCFS, POL_SSTF, POL_SSTF, POL_FCFS,
                                               POL_SSTF, POL_FCFS, POL_SSTF, POL_SSTF};
    localparam int      SRC_IDLE  [4]      = '{0, 65, 0, 24};
    localparam int      SNK_STALL [4]      = '{0, 0, 65, 24};

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [2:0]            paddr     = '0;
    logic [31:0]           pwdata    = '0;
    wire logic             s_tready;
    wire logic             m_tvalid;
    wire logic [M_DATA_W-1:0] m_tdata;
    wire logic [1:0]       m_tuser;
    wire logic [31:0]      prdata;
    wire logic             pready;

    logic                  tbl_used [DEPTH];
    t_slot                 tbl_req  [DEPTH];
    logic [BLOCK_W-1:0]    head_pos;
    logic [SUM_W-1:0]      lat_total;
    logic [CNT_W-1:0]      served_cnt;
    t_policy               cur_policy;
    logic [ROT_W-1:0]      cur_rot;
    t_disp_result          pending_results [$];
    int                    mismatch_count = 0;
    int                    src_idle_pct   = 0;
    int                    snk_stall_pct  = 0;

    sstf_fcfs_disk_request_scheduler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [BLOCK_W-1:0] seek_dist(logic [BLOCK_W-1:0] a,
                                                     logic [BLOCK_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic t_disp_result sched_predict(t_op op, t_slot req);
        t_disp_result       res;
        int                 pick;
        logic [31:0]        best;
        logic [31:0]        score;
        logic [BLOCK_W-1:0] seek_len;
        res  = '0;
        pick = -1;
        best = SCORE_NONE;
        if (op == OP_ENQ) begin
            res.st = ST_FULL;
            for (int i = 0; i < DEPTH; i++) begin
                if (!tbl_used[i] && pick < 0) pick = i;
            end
            if (pick >= 0) begin
                tbl_used[pick] = 1'b1;
                tbl_req[pick]  = req;
                res.st         = ST_ENQUEUED;
            end
        end else begin
            res.st = ST_EMPTY;
            for (int i = 0; i < DEPTH; i++) begin
                if (tbl_used[i]) begin
                    score = 32'(seek_dist(tbl_req[i].blk, head_pos)) * SEEK_WEIGHT
                            + 32'(tbl_req[i].prio);
                    if (cur_policy == POL_FCFS) begin
                        if (pick < 0) pick = i;
                    end else if (score < best) begin
                        best = score;
                        pick = i;
                    end
                end
            end
            if (pick >= 0) begin
                seek_len       = seek_dist(tbl_req[pick].blk, head_pos);
                res.st         = ST_DISPATCHED;
                res.blk        = tbl_req[pick].blk;
                res.wr         = tbl_req[pick].wr;
                res.prio       = tbl_req[pick].prio;
                res.tag        = tbl_req[pick].tag;
                res.lat        = LAT_W'(seek_len) + LAT_W'(cur_rot);
                tbl_used[pick] = 1'b0;
                head_pos       = tbl_req[pick].blk;
                if (lat_total > SUM_CEIL - SUM_W'(res.lat)) lat_total = SUM_CEIL;
                else lat_total = lat_total + SUM_W'(res.lat);
                if (served_cnt != CNT_CEIL) served_cnt = served_cnt + 1'b1;
            end
        end
        res.sum = lat_total;
        res.cnt = served_cnt;
        return res;
    endfunction

    function automatic t_slot random_req();
        t_slot req;
        req = {TAG_W'($urandom), PRIO_W'($urandom), 1'($urandom), BLOCK_W'($urandom)};
        case ($urandom_range(7))
            0: req.blk = '0;
            1: req.blk = '1;
            2, 3: req.blk = BLOCK_W'($urandom_range(15));
            4: req.blk = head_pos + BLOCK_W'($urandom_range(6)) - BLOCK_W'(3);
            default: ;
        endcase
        return req;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want_v);
        if (mismatch_count < PRINT_CAP)
            $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want_v);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want_v);
        if (got !== want_v) report_mismatch(what, got, want_v);
    endtask

    task automatic send_beat(input t_op op, input t_slot req, input logic typed,
                             input t_disp_result want);
        t_disp_result got;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, req};
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        got = sched_predict(op, req);
        pending_results.push_back(typed ? want : got);
    endtask

    // leaves psel high so that writes can follow back to back
    task automatic reg_write(input t_reg idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_POLICY) cur_policy = t_policy'(value[0]);
        else cur_rot = value[ROT_W-1:0];
    endtask

    always @(posedge i_clk) begin
        t_disp_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", 64'(m_tuser), 64'h0);
            end else begin
                want = pending_results.pop_front();
                check_field("status",       64'(m_tuser),          64'(want.st));
                check_field("out_block",    64'(m_tdata[19:0]),    64'(want.blk));
                check_field("out_write",    64'(m_tdata[20]),      64'(want.wr));
                check_field("out_prio",     64'(m_tdata[22:21]),   64'(want.prio));
                check_field("out_tag",      64'(m_tdata[38:23]),   64'(want.tag));
                check_field("latency",      64'(m_tdata[59:39]),   64'(want.lat));
                check_field("sum_latency",  64'(m_tdata[107:60]),  64'(want.sum));
                check_field("served_total", 64'(m_tdata[139:108]), 64'(want.cnt));
            end
        end
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    initial begin
        logic [ROT_W-1:0] rot;
        t_op              op;
        int               enq_pct;
        head_pos   = '0;
        lat_total  = '0;
        served_cnt = '0;
        cur_policy = POL_FCFS;
        cur_rot    = '0;
        enq_pct    = 50;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_used[i] = 1'b0;
            tbl_req[i]  = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_beat(DIR[r].op, {DIR[r].tag, DIR[r].prio, DIR[r].wr, DIR[r].blk},
                      DIR[r].typed, DIR[r].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            // drain before touching the registers
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge i_clk);
            case (p)
                2, 3: rot = '1;
                4, 6: rot = ROT_W'($urandom);
                5: rot = ROT_W'(1);
                default: rot = '0;
            endcase
            reg_write(REG_POLICY, 32'(PH_POL[p]));
            reg_write(REG_ROT, 32'(rot));
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            src_idle_pct  = SRC_IDLE[p % 4];
            snk_stall_pct = SNK_STALL[p % 4];
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // switch at random between filling, mixed and draining bursts
                if (n % 24 == 0) begin
                    case ($urandom_range(2))
                        0: enq_pct = 85;
                        1: enq_pct = 50;
                        default: enq_pct = 15;
                    endcase
                end
                op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DISP;
                send_beat(op, random_req(), 1'b0, NO_WANT);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("sstf_fcfs_disk_request_scheduler verification clean");
        else
            $display("sstf_fcfs_disk_request_scheduler verification failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("sstf_fcfs_disk_request_scheduler verification failed");
        $finish;
    end

endmodule

>>> sstf_fcfs_disk_request_scheduler.f
sv/sdrs_pkg.sv
sv/sdrs_ram.sv
sv/sdrs_score.sv
sv/sstf_fcfs_disk_request_scheduler.sv
verif/tb_top.sv
